>>> design/gnbm_pkg.sv
`timescale 1ns / 1ps
package gnbm_pkg;

	// Fixed-point precision of the logarithm and square root.
	localparam int FRAC_BITS = 28;

	// Uniform generator.
	localparam int LCG_W = 31;
	localparam logic [LCG_W-1:0] LCG_MOD = 31'h7FFF_FFFF;
	localparam logic [14:0] LCG_MUL = 15'd16807;

	// Widths that follow from the precision.
	localparam int LOGK_W = 5;
	localparam int LOG_W = LOGK_W + FRAC_BITS;
	localparam int W_W = LOG_W + 1;
	localparam int ROOT_W = (W_W + FRAC_BITS + 1) / 2;
	localparam int RAD_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 3;
	localparam int CNT_W = $clog2(ROOT_W + 1);
	localparam int PROD_W = ROOT_W + 31;
	localparam int IP_W = PROD_W - FRAC_BITS;
	localparam int TOT_W = IP_W + 2;

	// Cosine series.
	localparam int TERMS = 13;
	localparam int TERM_IDX_W = 4;
	localparam logic [64:0] TWO64 = 65'd1 << 64;
	localparam logic [63:0] TWO_LN2_Q63 = 64'hB172_17F7_D1CF_79AB;
	localparam logic [63:0] TWO_PI_Q60 = 64'h6487_ED51_10B4_611A;
	localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;

	// Divisors (2k-1)(2k) of the series terms and their reciprocals in Q64.
	localparam logic [63:0] DIV_TAB [TERMS] = '{
		64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182,
		64'd240, 64'd306, 64'd380, 64'd462, 64'd552, 64'd650
	};
	localparam logic [63:0] RECIP_TAB [TERMS] = '{
		64'(TWO64 / 65'd2), 64'(TWO64 / 65'd12), 64'(TWO64 / 65'd30),
		64'(TWO64 / 65'd56), 64'(TWO64 / 65'd90), 64'(TWO64 / 65'd132),
		64'(TWO64 / 65'd182), 64'(TWO64 / 65'd240), 64'(TWO64 / 65'd306),
		64'(TWO64 / 65'd380), 64'(TWO64 / 65'd462), 64'(TWO64 / 65'd552),
		64'(TWO64 / 65'd650)
	};

	// Configuration port.
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_STD_DEV = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MEAN = 4'd1;

	typedef enum logic {
		ITEM_DRAW = 1'b0,
		ITEM_SEED = 1'b1
	} item_op_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_LCG1, ST_LCG2, ST_LOG_INIT, ST_LOG_MUL, ST_LOG_WAIT, ST_LOG_SAVE,
		ST_W_MUL, ST_W_WAIT, ST_SQ_STEP, ST_PHI_MUL, ST_PHI_WAIT, ST_PHI2_MUL,
		ST_PHI2_WAIT, ST_T_MUL, ST_T_WAIT, ST_R_MUL, ST_R_WAIT, ST_Q_MUL, ST_Q_WAIT,
		ST_CORR, ST_CLAMP, ST_G_MUL, ST_G_WAIT, ST_P_MUL, ST_P_WAIT, ST_OUT
	} ctrl_state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_SEED, OP_LCG1, OP_LCG2, OP_LOG_INIT, OP_LOG_UPD, OP_LOG_SAVE_M,
		OP_D, OP_W, OP_SQ_STEP, OP_PHI, OP_PHI2, OP_X, OP_Q, OP_REM, OP_CORR,
		OP_TERM, OP_CLAMP, OP_G, OP_P, OP_OUT
	} dp_op_t;

	typedef enum logic [3:0] {
		MS_LOG, MS_W, MS_PHI, MS_PHI2, MS_T, MS_R, MS_Q, MS_G, MS_P
	} mul_sel_t;

	typedef struct packed {
		dp_op_t op;
		logic mul_go;
		mul_sel_t msel;
		logic sel_u;
		logic [TERM_IDX_W-1:0] term;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic corr_needed;
		logic out_full;
	} dp_stat_t;

endpackage

>>> design/gnbm_if.sv
`timescale 1ns / 1ps

// Input items.
interface gnbm_in_if import gnbm_pkg::*; ();
	logic valid;
	logic ready;
	logic operation;
	logic [LCG_W-1:0] seed_value;

	modport source(output valid, output operation, output seed_value, input ready);
	modport sink(input valid, input operation, input seed_value, output ready);
endinterface

// Result items.
interface gnbm_out_if import gnbm_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [31:0] sample;

	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface

// Register writes.
interface gnbm_cfg_if import gnbm_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

>>> design/gnbm_mul.sv
`timescale 1ns / 1ps
module gnbm_mul import gnbm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic         wide,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic         done,
	output logic [127:0] p
);

	logic [63:0]  a_q;
	logic [63:0]  b_q;
	logic         wide_q;
	logic         run_q;
	logic [1:0]   idx_q;
	logic         done_q;
	logic [63:0]  pp_s1;
	logic [1:0]   pp_idx_s1;
	logic         pp_vld_s1;
	logic         pp_last_s1;
	logic [127:0] acc_q;
	logic [31:0]  a_part;
	logic [31:0]  b_part;
	logic         last;
	logic [127:0] pp_shift;

	// Partial product selection: a0*b0, a0*b1, a1*b0, a1*b1.
	always_comb begin
		a_part = idx_q[1] ? a_q[63:32] : a_q[31:0];
		b_part = idx_q[0] ? b_q[63:32] : b_q[31:0];
		last = !wide_q || (idx_q == 2'd3);
		unique case (pp_idx_s1)
			2'd0:    pp_shift = {64'd0, pp_s1};
			2'd3:    pp_shift = {pp_s1, 64'd0};
			default: pp_shift = {32'd0, pp_s1, 32'd0};
		endcase
	end

	// Sequencing of the partial products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			idx_q <= '0;
			pp_vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				idx_q <= '0;
				pp_vld_s1 <= 1'b0;
			end else begin
				pp_vld_s1 <= run_q;
				if (run_q) begin
					idx_q <= idx_q + 2'd1;
					if (last) begin
						run_q <= 1'b0;
					end
				end
				if (pp_vld_s1 && pp_last_s1) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// One 32x32 product per cycle, then accumulation.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			wide_q <= wide;
			acc_q <= '0;
		end else begin
			if (run_q) begin
				pp_s1 <= 64'(a_part) * 64'(b_part);
				pp_idx_s1 <= idx_q;
				pp_last_s1 <= last;
			end
			if (pp_vld_s1) begin
				acc_q <= acc_q + pp_shift;
			end
		end
	end

	assign done = done_q;
	assign p = acc_q;

endmodule

>>> design/gnbm_ctrl.sv
`timescale 1ns / 1ps
module gnbm_ctrl import gnbm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_operation,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;
	logic pass_q;
	logic pass_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			pass_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			pass_q <= pass_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		pass_d = pass_q;
		in_ready = 1'b0;
		cmd.op = OP_NONE;
		cmd.mul_go = 1'b0;
		cmd.msel = MS_LOG;
		cmd.sel_u = pass_q;
		cmd.term = cnt_q[TERM_IDX_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (item_op_t'(in_operation) == ITEM_SEED) begin
						cmd.op = OP_SEED;
					end else begin
						state_d = ST_LCG1;
					end
				end
			end
			ST_LCG1: begin
				cmd.op = OP_LCG1;
				state_d = ST_LCG2;
			end
			ST_LCG2: begin
				cmd.op = OP_LCG2;
				pass_d = 1'b0;
				state_d = ST_LOG_INIT;
			end
			ST_LOG_INIT: begin
				cmd.op = OP_LOG_INIT;
				cnt_d = '0;
				state_d = ST_LOG_MUL;
			end
			ST_LOG_MUL: begin
				cmd.mul_go = 1'b1;
				cmd.msel = MS_LOG;
				state_d = ST_LOG_WAIT;
			end
			ST_LOG_WAIT: begin
				if (stat.mul_done) begin
					cmd.op = OP_LOG_UPD;
					if (cnt_q == CNT_W'(FRAC_BITS - 1)) begin
						cnt_d = '0;
						state_d = ST_LOG_SAVE;
					end else begin
						cnt_d = cnt_q + 1'b1;
						state_d = ST_LOG_MUL;
					end
				end
			end
			ST_LOG_SAVE: begin
				if (!pass_q) begin
					cmd.op = OP_LOG_SAVE_M;
					pass_d = 1'b1;
					state_d = ST_LOG_INIT;
				end else begin
					cmd.op = OP_D;
					state_d = ST_W_MUL;
				end
			end
			ST_W_MUL: begin
				cmd.mul_go = 1'b1;
				cmd.msel = MS_W;
				state_d = ST_W_WAIT;
			end
			ST_W_WAIT: begin
				if (stat.mul_done) begin
					cmd.op = OP_W;
					cnt_d = '0;
					state_d = ST_SQ_STEP;
				end
			end
			ST_SQ_STEP: begin
				cmd.op = OP_SQ_STEP;
				if (cnt_q == CNT_W'(ROOT_W - 1)) begin
					cnt_d = '0;
					state_d = ST_PHI_MUL;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_PHI_MUL: begin
				cmd.mul_go = 1'b1;
				cmd.msel = MS_PHI;
				state_d = ST_PHI_WAIT;
			end
			ST_PHI_WAIT: begin
				if (stat.mul_done) begin
					cmd.op = OP_PHI;
					state_d = ST_PHI2_MUL;
				end
			end
			ST_PHI2_MUL: begin
				cmd.mul_go = 1'b1;
				cmd.msel = MS_PHI2;
				state_d = ST_PHI2_WAIT;
			end
			ST_PHI2_WAIT: begin
				if (stat.mul_done) begin
					cmd.op = OP_PHI2;
					cnt_d = '0;
					state_d = ST_T_MUL;
				end
			end
			ST_T_MUL: begin
				cmd.mul_go = 1'b1;
				cmd.msel = MS_T;
				state_d = ST_T_WAIT;
			end
			ST_T_WAIT: begin
				if (stat.mul_done) begin
					cmd.op = OP_X;
					state_d = ST_R_MUL;
				end
			end
			ST_R_MUL: begin
				cmd.mul_go = 1'b1;
				cmd.msel = MS_R;
				state_d = ST_R_WAIT;
			end
			ST_R_WAIT: begin
				if (stat.mul_done) begin
					cmd.op = OP_Q;
					state_d = ST_Q_MUL;
				end
			end
			ST_Q_MUL: begin
				cmd.mul_go = 1'b1;
				cmd.msel = MS_Q;
				state_d = ST_Q_WAIT;
			end
			ST_Q_WAIT: begin
				if (stat.mul_done) begin
					cmd.op = OP_REM;
					state_d = ST_CORR;
				end
			end
			ST_CORR: begin
				// The reciprocal quotient may fall short by a few units.
				if (stat.corr_needed) begin
					cmd.op = OP_CORR;
				end else begin
					cmd.op = OP_TERM;
					if (cnt_q == CNT_W'(TERMS - 1)) begin
						cnt_d = '0;
						state_d = ST_CLAMP;
					end else begin
						cnt_d = cnt_q + 1'b1;
						state_d = ST_T_MUL;
					end
				end
			end
			ST_CLAMP: begin
				cmd.op = OP_CLAMP;
				state_d = ST_G_MUL;
			end
			ST_G_MUL: begin
				cmd.mul_go = 1'b1;
				cmd.msel = MS_G;
				state_d = ST_G_WAIT;
			end
			ST_G_WAIT: begin
				if (stat.mul_done) begin
					cmd.op = OP_G;
					state_d = ST_P_MUL;
				end
			end
			ST_P_MUL: begin
				cmd.mul_go = 1'b1;
				cmd.msel = MS_P;
				state_d = ST_P_WAIT;
			end
			ST_P_WAIT: begin
				if (stat.mul_done) begin
					cmd.op = OP_P;
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!stat.out_full) begin
					cmd.op = OP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> design/gnbm_dp.sv
`timescale 1ns / 1ps
module gnbm_dp import gnbm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	output dp_stat_t         stat,
	input  logic [LCG_W-1:0] seed_value,
	gnbm_cfg_if.sink         cfg,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [31:0]      out_sample
);

	localparam logic signed [TOT_W-1:0] SAT_MAX = {{(TOT_W - 31){1'b0}}, {31{1'b1}}};
	localparam logic signed [TOT_W-1:0] SAT_MIN = {{(TOT_W - 31){1'b1}}, 31'd0};
	localparam logic signed [TOT_W-1:0] TOT_ONE = TOT_W'(1);

	// Architectural and configuration state.
	logic [LCG_W-1:0] lcg_q;
	logic [30:0]      std_dev_q;
	logic [31:0]      mean_q;
	logic             out_valid_q;
	logic [31:0]      sample_q;

	// Working registers.
	logic [LCG_W-1:0]      s1_q;
	logic [LCG_W-1:0]      s2_q;
	logic [31:0]           t_q;
	logic [30:0]           tf_q;
	logic                  neg_q;
	logic [31:0]           y_q;
	logic [LOGK_W-1:0]     k_q;
	logic [FRAC_BITS-1:0]  bits_q;
	logic [LOG_W-1:0]      lm_q;
	logic [LOG_W-1:0]      d_q;
	logic [RAD_W-1:0]      rad_q;
	logic [REM_W-1:0]      srem_q;
	logic [ROOT_W-1:0]     root_q;
	logic [63:0]           x_q;
	logic [63:0]           phi2_q;
	logic [63:0]           term_q;
	logic signed [63:0]    sum_q;
	logic [63:0]           q_q;
	logic [63:0]           rem_q;
	logic [ROOT_W-1:0]     g_q;
	logic [PROD_W-1:0]     prod_q;

	// Combinational helpers.
	logic [LCG_W-1:0]     lcg1;
	logic [LCG_W-1:0]     lcg2;
	logic [LCG_W-1:0]     log_x;
	logic [LOGK_W-1:0]    log_k;
	logic [31:0]          log_y;
	logic [32:0]          sq;
	logic [31:0]          two_s2;
	logic [31:0]          t_new;
	logic [31:0]          t_half;
	logic [LOG_W-1:0]     lu;
	logic [W_W-1:0]       w_new;
	logic [REM_W-1:0]     srem_sh;
	logic [REM_W-1:0]     trial;
	logic [63:0]          div_k;
	logic [IP_W-1:0]      ip;
	logic                 frac;
	logic signed [TOT_W-1:0] mean_x;
	logic signed [TOT_W-1:0] ip_x;
	logic signed [TOT_W-1:0] tot;
	logic [31:0]          sat;
	logic [63:0]          mul_a;
	logic [63:0]          mul_b;
	logic                 mul_done;
	logic [127:0]         mul_p;

	function automatic logic [LCG_W-1:0] lcg_next(input logic [LCG_W-1:0] s);
		logic [45:0] p;
		logic [31:0] r;
		p = 46'(s) * 46'(LCG_MUL);
		// 2^31 is 1 modulo the prime, so the high part folds onto the low part.
		r = 32'(p[30:0]) + 32'(p[45:31]);
		if (r >= 32'(LCG_MOD)) begin
			r = r - 32'(LCG_MOD);
		end
		return r[LCG_W-1:0];
	endfunction

	// Shared multiplier.
	gnbm_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_go),
		.wide   (cmd.msel != MS_LOG),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	// Multiplier operand selection.
	always_comb begin
		unique case (cmd.msel)
			MS_LOG: begin
				mul_a = 64'(y_q);
				mul_b = 64'(y_q);
			end
			MS_W: begin
				mul_a = 64'(d_q);
				mul_b = TWO_LN2_Q63;
			end
			MS_PHI: begin
				mul_a = 64'(tf_q);
				mul_b = TWO_PI_Q60;
			end
			MS_PHI2: begin
				mul_a = x_q;
				mul_b = x_q;
			end
			MS_T: begin
				mul_a = term_q;
				mul_b = phi2_q;
			end
			MS_R: begin
				mul_a = x_q;
				mul_b = RECIP_TAB[cmd.term];
			end
			MS_Q: begin
				mul_a = q_q;
				mul_b = DIV_TAB[cmd.term];
			end
			MS_G: begin
				mul_a = 64'(root_q);
				mul_b = term_q;
			end
			MS_P: begin
				mul_a = 64'(g_q);
				mul_b = 64'(std_dev_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Uniform source, logarithm normalization and angle.
	always_comb begin
		lcg1 = lcg_next(lcg_q);
		lcg2 = lcg_next(lcg_q);
		log_x = cmd.sel_u ? s1_q : LCG_MOD;
		log_k = '0;
		for (int i = 1; i < LCG_W; i++) begin
			if (log_x[i]) begin
				log_k = LOGK_W'(i);
			end
		end
		log_y = {1'b0, log_x} << (5'd31 - log_k);
		sq = mul_p[63:31];
		two_s2 = {s2_q, 1'b0};
		t_new = two_s2 + 32'(two_s2 >= 32'(LCG_MOD));
		t_half = t_q[31] ? (32'd0 - t_q) : t_q;
		lu = {k_q, bits_q};
		w_new = mul_p[63 +: W_W];
	end

	// Square root step and series divisor.
	always_comb begin
		srem_sh = {srem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
		trial = REM_W'({root_q, 2'b01});
		div_k = DIV_TAB[cmd.term];
	end

	// Final scaling, rounding toward zero and saturation.
	always_comb begin
		ip = prod_q[FRAC_BITS +: IP_W];
		frac = |prod_q[FRAC_BITS-1:0];
		mean_x = {{(TOT_W - 32){mean_q[31]}}, mean_q};
		ip_x = {2'b00, ip};
		if (!neg_q) begin
			tot = mean_x + ip_x;
			if (tot < 0 && frac) begin
				tot = tot + TOT_ONE;
			end
		end else begin
			tot = mean_x - ip_x;
			if (tot >= TOT_ONE && frac) begin
				tot = tot - TOT_ONE;
			end
		end
		if (tot > SAT_MAX) begin
			sat = 32'h7FFF_FFFF;
		end else if (tot < SAT_MIN) begin
			sat = 32'h8000_0000;
		end else begin
			sat = tot[31:0];
		end
	end

	// Generator state, configuration registers and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcg_q <= LCG_W'(1);
			std_dev_q <= 31'd1;
			mean_q <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				if (cfg.index == REG_STD_DEV) begin
					std_dev_q <= cfg.data[30:0];
				end else if (cfg.index == REG_MEAN) begin
					mean_q <= cfg.data;
				end
			end
			if (cmd.op == OP_SEED) begin
				if (seed_value == '0 || seed_value == LCG_MOD) begin
					lcg_q <= LCG_W'(1);
				end else begin
					lcg_q <= seed_value;
				end
			end else if (cmd.op == OP_LCG1) begin
				lcg_q <= lcg1;
			end else if (cmd.op == OP_LCG2) begin
				lcg_q <= lcg2;
			end
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers, one operation per command.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LCG1: begin
				s1_q <= lcg1;
			end
			OP_LCG2: begin
				s2_q <= lcg2;
			end
			OP_LOG_INIT: begin
				y_q <= log_y;
				k_q <= log_k;
				bits_q <= '0;
				t_q <= t_new;
			end
			OP_LOG_UPD: begin
				bits_q <= {bits_q[FRAC_BITS-2:0], sq[32]};
				y_q <= sq[32] ? sq[32:1] : sq[31:0];
			end
			OP_LOG_SAVE_M: begin
				lm_q <= lu;
			end
			OP_D: begin
				d_q <= (lm_q > lu) ? (lm_q - lu) : '0;
				if (t_half > 32'h4000_0000) begin
					tf_q <= 31'(32'h8000_0000 - t_half);
					neg_q <= 1'b1;
				end else begin
					tf_q <= t_half[30:0];
					neg_q <= 1'b0;
				end
			end
			OP_W: begin
				rad_q <= RAD_W'({w_new, {FRAC_BITS{1'b0}}});
				srem_q <= '0;
				root_q <= '0;
			end
			OP_SQ_STEP: begin
				rad_q <= {rad_q[RAD_W-3:0], 2'b00};
				if (srem_sh >= trial) begin
					srem_q <= srem_sh - trial;
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					srem_q <= srem_sh;
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
			end
			OP_PHI: begin
				x_q <= mul_p[32 +: 64];
			end
			OP_PHI2: begin
				phi2_q <= mul_p[60 +: 64];
				term_q <= ONE_Q60;
				sum_q <= signed'(ONE_Q60);
			end
			OP_X: begin
				x_q <= mul_p[60 +: 64];
			end
			OP_Q: begin
				q_q <= mul_p[127:64];
			end
			OP_REM: begin
				rem_q <= x_q - mul_p[63:0];
			end
			OP_CORR: begin
				q_q <= q_q + 64'd1;
				rem_q <= rem_q - div_k;
			end
			OP_TERM: begin
				// Odd-numbered terms of the series are subtracted.
				term_q <= q_q;
				if (!cmd.term[0]) begin
					sum_q <= sum_q - signed'(q_q);
				end else begin
					sum_q <= sum_q + signed'(q_q);
				end
			end
			OP_CLAMP: begin
				if (sum_q < 0) begin
					term_q <= '0;
				end else if (sum_q > signed'(ONE_Q60)) begin
					term_q <= ONE_Q60;
				end else begin
					term_q <= sum_q;
				end
			end
			OP_G: begin
				g_q <= mul_p[60 +: ROOT_W];
			end
			OP_P: begin
				prod_q <= mul_p[PROD_W-1:0];
			end
			OP_OUT: begin
				sample_q <= sat;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		stat.mul_done = mul_done;
		stat.corr_needed = rem_q >= div_k;
		stat.out_full = out_valid_q && !out_ready;
	end

	assign cfg.ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_sample = sample_q;

endmodule

>>> design/gaussian_noise_box_muller.sv
`timescale 1ns / 1ps
// Gaussian noise source: Box-Muller transform over a Park-Miller uniform generator.
// in_item carries an operation bit and a seed. A seed beat loads the generator
// state in the cycle it is accepted and gives no result. A draw beat advances
// the generator twice and delivers one signed 32-bit sample on out_item:
// mean + std_dev * sqrt(-2 ln u) * cos(2 pi v), truncated toward zero and saturated.
// cfg writes std_dev (index 0) and mean (index 1); other indexes are ignored.
// Writes are taken every cycle and belong between items.
// A draw's length is set by the single 32x32 multiplier that all products share, a
// 64x64 product being built from four partial products: two 28-step logarithms, a
// 31-step square root and 13 series terms of three products each, plus a correction
// step each time a series term's reciprocal quotient falls short. One draw is in
// flight at a time; in_item is ready only while the controller is idle, so a new
// draw is not taken before the last one has finished, and seed beats can follow
// each other every cycle.
// The result sits in an output register; the next beat is accepted while it
// waits, and a stalled receiver holds only the next finished sample back.
// Reset sets the generator state to 1, std_dev to 1, mean to 0 and empties the
// output register.
module gaussian_noise_box_muller import gnbm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	gnbm_in_if.sink    in_item,
	gnbm_out_if.source out_item,
	gnbm_cfg_if.sink   cfg
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     in_ready;
	logic     out_valid;
	logic [31:0] out_sample;

	gnbm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_item.valid),
		.in_operation (in_item.operation),
		.in_ready     (in_ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	gnbm_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.seed_value (in_item.seed_value),
		.cfg        (cfg),
		.out_valid  (out_valid),
		.out_ready  (out_item.ready),
		.out_sample (out_sample)
	);

	assign in_item.ready = in_ready;
	assign out_item.valid = out_valid;
	assign out_item.sample = out_sample;

endmodule
